// ===== src/user_agent_stream_classifier_defines.svh =====
// Assertion macros for the user-agent stream classifier checker.
// No dependencies; included by the checker file only.
`ifndef USER_AGENT_STREAM_CLASSIFIER_DEFINES_SVH
`define USER_AGENT_STREAM_CLASSIFIER_DEFINES_SVH

// Property checked on every edge outside reset.
`define UASC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define UASC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/uasc_pkg.sv =====
// Shared types, class codes and marker tables for the user-agent classifier.
// No dependencies; used by uasc_match, uasc_core and the top level.
package uasc_pkg;

  localparam int WINDOW_LEN_DEF = 19;
  localparam int MATCH_BYTES    = 19;  // longest marker
  localparam int MATCH_W        = 8 * MATCH_BYTES;
  localparam int N_BOT          = 11;
  localparam int N_MOB          = 6;

  localparam logic [1:0] CLASS_DESKTOP = 2'd0;
  localparam logic [1:0] CLASS_MOBILE  = 2'd1;
  localparam logic [1:0] CLASS_BOT     = 2'd2;

  typedef struct packed {
    logic no_char;
    logic is_last;
  } uasc_ctl_t;

  typedef struct packed {
    logic bot;
    logic mobile;
  } uasc_hits_t;

  // Marker text: first character in the highest byte, last character in byte 0.
  localparam logic [MATCH_W-1:0] BOT_TEXT [N_BOT] = '{
    MATCH_W'("bot"),
    MATCH_W'("crawler"),
    MATCH_W'("spider"),
    MATCH_W'("slurp"),
    MATCH_W'("curl"),
    MATCH_W'("wget"),
    MATCH_W'("python-requests"),
    MATCH_W'("headlesschrome"),
    MATCH_W'(120'h79616e6465782e636f6d2f626f7473),
    MATCH_W'(152'h66616365626f6f6b65787465726e616c686974),
    MATCH_W'("preview")
  };
  localparam logic [4:0] BOT_LEN [N_BOT] = '{
    5'd3, 5'd7, 5'd6, 5'd5, 5'd4, 5'd4, 5'd15, 5'd14, 5'd15, 5'd19, 5'd7
  };

  localparam logic [MATCH_W-1:0] MOB_TEXT [N_MOB] = '{
    MATCH_W'("mobile"),
    MATCH_W'("android"),
    MATCH_W'("iphone"),
    MATCH_W'("ipad"),
    MATCH_W'("ipod"),
    MATCH_W'("opera mini")
  };
  localparam logic [4:0] MOB_LEN [N_MOB] = '{
    5'd6, 5'd7, 5'd6, 5'd4, 5'd4, 5'd10
  };

  // Byte mask covering the low len bytes.
  function automatic logic [MATCH_W-1:0] len_mask(input logic [4:0] len);
    logic [MATCH_W-1:0] m;
    m = '0;
    for (int i = 0; i < MATCH_BYTES; i++) begin
      if (i < int'(len)) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

// ===== src/uasc_match.sv =====
// Parallel marker comparators against the newest bytes of the window.
// Depends on uasc_pkg (marker tables, hit struct).
module uasc_match (
  input  logic [uasc_pkg::MATCH_W-1:0] win_flat,  // byte 0 is newest
  output uasc_pkg::uasc_hits_t         hits
);

  logic [uasc_pkg::N_BOT-1:0] bot_vec;
  logic [uasc_pkg::N_MOB-1:0] mob_vec;

  always_comb begin
    for (int i = 0; i < uasc_pkg::N_BOT; i++) begin
      bot_vec[i] = ((win_flat ^ uasc_pkg::BOT_TEXT[i]) &
                    uasc_pkg::len_mask(uasc_pkg::BOT_LEN[i])) == '0;
    end
    for (int j = 0; j < uasc_pkg::N_MOB; j++) begin
      mob_vec[j] = ((win_flat ^ uasc_pkg::MOB_TEXT[j]) &
                    uasc_pkg::len_mask(uasc_pkg::MOB_LEN[j])) == '0;
    end
  end

  assign hits.bot    = |bot_vec;
  assign hits.mobile = |mob_vec;

endmodule

// ===== src/uasc_core.sv =====
// Byte window, sticky flags and class decision for one string.
// Depends on uasc_pkg and uasc_match.
module uasc_core #(
  parameter int WINDOW_LEN = uasc_pkg::WINDOW_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,       // request in the input register moves on
  input  logic [7:0]          ua_char,
  input  uasc_pkg::uasc_ctl_t ctl,
  output logic [1:0]          agent_class // valid when step and ctl.is_last
);

  logic [7:0] win_r   [WINDOW_LEN];
  logic [7:0] win_nxt [WINDOW_LEN];
  logic       bot_r, mob_r, seen_r;
  logic       bot_nxt, mob_nxt, seen_nxt;
  logic [7:0] lc;
  logic       take;
  logic [uasc_pkg::MATCH_W-1:0] flat;
  uasc_pkg::uasc_hits_t hits;

  assign lc   = (ua_char >= 8'h41 && ua_char <= 8'h5A) ? ua_char + 8'd32 : ua_char;
  assign take = step && !ctl.no_char;

  always_comb begin
    win_nxt[0] = lc;
    for (int i = 1; i < WINDOW_LEN; i++) win_nxt[i] = win_r[i-1];
    for (int k = 0; k < uasc_pkg::MATCH_BYTES; k++) flat[8*k +: 8] = win_nxt[k];
  end

  uasc_match u_match (
    .win_flat (flat),
    .hits     (hits)
  );

  assign bot_nxt  = bot_r  | (take & hits.bot);
  assign mob_nxt  = mob_r  | (take & hits.mobile);
  assign seen_nxt = seen_r | take;

  always_comb begin
    if (bot_nxt)        agent_class = uasc_pkg::CLASS_BOT;
    else if (mob_nxt)   agent_class = uasc_pkg::CLASS_MOBILE;
    else if (!seen_nxt) agent_class = uasc_pkg::CLASS_BOT;   // empty string
    else                agent_class = uasc_pkg::CLASS_DESKTOP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && ctl.is_last)) begin
      for (int i = 0; i < WINDOW_LEN; i++) win_r[i] <= 8'h00;
      bot_r  <= 1'b0;
      mob_r  <= 1'b0;
      seen_r <= 1'b0;
    end else if (take) begin
      win_r  <= win_nxt;
      bot_r  <= bot_nxt;
      mob_r  <= mob_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// ===== src/user_agent_stream_classifier.sv =====
// Top level of the user-agent stream classifier: handshake, input and result registers.
// Depends on uasc_pkg and uasc_core (which holds uasc_match).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in_     | input     | in_valid/in_stall  | in_ua_char, in_no_char, in_is_last
//  out_    | output    | out_valid/out_stall| out_agent_class
//
// One request per cycle unless a last request waits on a held result. The compare
// of the window is combinational; a last request's class is registered as it moves on.
// Synchronous active-low reset clears the window, flags and both valids.
// A held result only blocks a last request waiting behind it; other
// requests keep flowing while out_stall is high, until a last request waits.
module user_agent_stream_classifier #(
  parameter int WINDOW_LEN = uasc_pkg::WINDOW_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ua_char,
  input  logic       in_no_char,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_agent_class
);

  // Input register
  logic                s1_valid_r, s1_valid_nxt;
  logic [7:0]          s1_char_r;
  uasc_pkg::uasc_ctl_t s1_ctl_r;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_class_r;

  logic                out_free;   // result register can take a new class
  logic                s1_go;      // request in the input register is processed
  logic                in_take;
  logic [1:0]          class_now;

  assign out_free = !out_valid_r || !out_stall;
  // Only a last request needs room in the result register.
  assign s1_go    = s1_valid_r && (!s1_ctl_r.is_last || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_go);
  assign out_valid_nxt = (s1_go && s1_ctl_r.is_last) || (out_valid_r && out_stall);

  uasc_core #(.WINDOW_LEN(WINDOW_LEN)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_go),
    .ua_char     (s1_char_r),
    .ctl         (s1_ctl_r),
    .agent_class (class_now)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r        <= in_ua_char;
      s1_ctl_r.no_char <= in_no_char;
      s1_ctl_r.is_last <= in_is_last;
    end
    if (s1_go && s1_ctl_r.is_last) out_class_r <= class_now;
  end

  assign out_valid       = out_valid_r;
  assign out_agent_class = out_class_r;

endmodule

// ===== src/uasc_checker.sv =====
// Port-level checker for the user-agent stream classifier, bound to the top level.
// Depends on user_agent_stream_classifier_defines.svh and uasc_pkg (class codes).
`include "user_agent_stream_classifier_defines.svh"

module uasc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_ua_char,
  input logic       in_no_char,
  input logic       in_is_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_agent_class
);

  `UASC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_agent_class), "held result changed")
  `UASC_ASSERT(a_class_legal, out_valid |-> out_agent_class <= uasc_pkg::CLASS_BOT, "illegal class code")
  `UASC_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without back pressure")
  `UASC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind user_agent_stream_classifier uasc_checker u_uasc_checker (.*);

// ===== sim/user_agent_stream_classifier_tb.sv =====
// Self-checking bench for user_agent_stream_classifier: directed strings, then random traffic.
// Depends on uasc_pkg (class codes) and the RTL top; the marker matcher here is the bench's own.
module user_agent_stream_classifier_tb;

  localparam int WIN          = uasc_pkg::WINDOW_LEN_DEF;
  localparam int RAND_ITEMS   = 1290;
  localparam int HOLD_CYCLES  = 400;   // one long receiver hold-off
  localparam int IDLE_LIMIT   = 3000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES = 8;     // margin after the owed-class queue empties

  // Marker table: last character in byte 0. Entries below N_BOT_MARK are bot markers.
  localparam int N_MARK     = 17;
  localparam int N_BOT_MARK = 11;
  localparam logic [151:0] MARK_TEXT [N_MARK] = '{
    152'("bot"), 152'("crawler"), 152'("spider"), 152'("slurp"),
    152'("curl"), 152'("wget"), 152'("python-requests"), 152'("headlesschrome"),
    152'(120'h79616e6465782e636f6d2f626f7473),              // search crawler path
    152'(152'h66616365626f6f6b65787465726e616c686974),      // link preview fetcher
    152'("preview"),
    152'("mobile"), 152'("android"), 152'("iphone"), 152'("ipad"),
    152'("ipod"), 152'("opera mini")
  };
  localparam int MARK_LEN [N_MARK] = '{
    3, 7, 6, 5, 4, 4, 15, 14, 15, 19, 7, 6, 7, 6, 4, 4, 10
  };

  // Directed strings. A byte-less item goes in before position gap_at (-1: none);
  // tail_empty ends the string with a byte-less last request.
  typedef struct {
    string      text;
    int         gap_at;
    bit         tail_empty;
    bit         cls_given;
    logic [1:0] cls;
  } ua_case_t;

  localparam int N_CASE = 15;
  ua_case_t ua_cases [N_CASE] = '{
    '{"",                          -1, 1'b1, 1'b1, uasc_pkg::CLASS_BOT},     // empty string
    '{"a",                         -1, 1'b0, 1'b1, uasc_pkg::CLASS_DESKTOP},
    '{"BOT",                       -1, 1'b0, 1'b1, uasc_pkg::CLASS_BOT},     // uppercase folds
    '{"iPhone",                    -1, 1'b0, 1'b1, uasc_pkg::CLASS_MOBILE},
    '{"bot",                        2, 1'b0, 1'b1, uasc_pkg::CLASS_BOT},     // hole mid-marker
    '{"Opera Mini",                -1, 1'b1, 1'b1, uasc_pkg::CLASS_MOBILE},  // last has no byte
    '{"android bot",               -1, 1'b0, 1'b1, uasc_pkg::CLASS_BOT},     // bot wins
    '{"xb",                        -1, 1'b0, 1'b1, uasc_pkg::CLASS_DESKTOP},
    '{"ot",                        -1, 1'b0, 1'b1, uasc_pkg::CLASS_DESKTOP}, // window cleared
    '{"@[`{",                      -1, 1'b0, 1'b1, uasc_pkg::CLASS_DESKTOP}, // around A-Z
    '{"\001\377",                  -1, 1'b0, 1'b1, uasc_pkg::CLASS_DESKTOP}, // byte extremes
    '{"HeadlessChrome",            -1, 1'b0, 1'b1, uasc_pkg::CLASS_BOT},
    '{"Linux; Android 10; Mobile", -1, 1'b0, 1'b0, uasc_pkg::CLASS_DESKTOP},
    '{"pythonrequests ipo",        -1, 1'b0, 1'b0, uasc_pkg::CLASS_DESKTOP},
    '{"IPAD",                      -1, 1'b0, 1'b1, uasc_pkg::CLASS_MOBILE}
  };

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_ua_char = 8'h00;
  logic       in_no_char = 1'b0;
  logic       in_is_last = 1'b0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [1:0] out_agent_class;

  // Typed-in class riding along with the request on the port (directed rows only).
  logic       row_cls_given = 1'b0;
  logic [1:0] row_cls       = uasc_pkg::CLASS_DESKTOP;

  // Bench copy of the classifier state.
  logic [7:0] ua_window [WIN];
  bit         saw_bot, saw_mobile, saw_byte;

  logic [1:0] agent_class_q [$];     // classes still owed by the block
  logic [7:0] str_bytes [$];         // string being sent
  bit         str_empty [$];         // matching no-byte flags

  int err_cnt   = 0;
  int n_items   = 0;
  int n_strings = 0;
  int n_results = 0;
  int n_class [3] = '{0, 0, 0};
  int burst_left = 0;
  bit hold_done = 1'b0;

  user_agent_stream_classifier #(.WINDOW_LEN(WIN)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ua_char      (in_ua_char),
    .in_no_char      (in_no_char),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_agent_class (out_agent_class)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Reset held low from the start, then released once.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // True when marker idx ends at the newest byte of the window.
  function automatic bit marker_ends(input int idx);
    for (int k = 0; k < MARK_LEN[idx]; k++) begin
      if (MARK_TEXT[idx][8*k +: 8] != ua_window[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_ua_state();
    for (int i = 0; i < WIN; i++) ua_window[i] = 8'h00;
    saw_bot    = 1'b0;
    saw_mobile = 1'b0;
    saw_byte   = 1'b0;
  endfunction

  // Takes one request; returns 1 and the class when the request closes the string.
  function automatic bit advance_ua_class(input logic [7:0] c, input bit empty, input bit last,
                                          output logic [1:0] cls);
    logic [7:0] lc;
    cls = uasc_pkg::CLASS_DESKTOP;
    if (!empty) begin
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      for (int i = WIN - 1; i > 0; i--) ua_window[i] = ua_window[i-1];
      ua_window[0] = lc;
      saw_byte = 1'b1;
      for (int m = 0; m < N_MARK; m++) begin
        if (marker_ends(m)) begin
          if (m < N_BOT_MARK) saw_bot = 1'b1;
          else saw_mobile = 1'b1;
        end
      end
    end
    if (!last) return 1'b0;
    // Precedence: bot marker, mobile marker, no byte at all (bot), desktop.
    if (saw_bot) cls = uasc_pkg::CLASS_BOT;
    else if (saw_mobile) cls = uasc_pkg::CLASS_MOBILE;
    else if (!saw_byte) cls = uasc_pkg::CLASS_BOT;
    else cls = uasc_pkg::CLASS_DESKTOP;
    clear_ua_state();
    return 1'b1;
  endfunction

  initial clear_ua_state();

  // Every accepted request goes through the predictor. Directed rows with a typed-in
  // class queue that value instead, so the block is held to the literal answer.
  always @(posedge clk) begin : in_mon
    logic [1:0] cls;
    if (rst_n && in_valid && !in_stall) begin
      if (advance_ua_class(in_ua_char, in_no_char, in_is_last, cls)) begin
        agent_class_q = {agent_class_q, (row_cls_given ? row_cls : cls)};
      end
    end
  end

  // Results are matched in order against the oldest owed class.
  always @(posedge clk) begin : out_mon
    logic [1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (agent_class_q.size() == 0) begin
        $display("%0t: result with no request pending, expected none, got %0d",
                 $time, out_agent_class);
        err_cnt++;
      end else begin
        want = agent_class_q.pop_front();
        if (out_agent_class !== want) begin
          $display("%0t: agent_class mismatch, expected %0d, got %0d",
                   $time, want, out_agent_class);
          err_cnt++;
        end
      end
      n_results++;
      if (out_agent_class <= uasc_pkg::CLASS_BOT) n_class[out_agent_class]++;
    end
  end

  // Watchdog: too long without a handshake on either channel ends the run.
  always @(posedge clk) begin : watchdog
    int idle;
    if (!rst_n) idle = 0;
    else if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
    else begin
      idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("user_agent_stream_classifier_tb failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern is redrawn after each random-length run; mode 0 never stalls.
  // Once enough results are in, it holds out_stall high in one long hold-off so the block backs up.
  // ---------------------------------------------------------------------------
  initial begin : rx_proc
    int mode;
    int tick;
    tick = 0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(16, 96)) begin
        @(posedge clk);
        tick++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          2: out_stall <= (tick % 3 == 0);
          default: out_stall <= ($urandom_range(0, 4) != 0);
        endcase
      end
      if (!hold_done && n_results >= 30) begin
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Drive one request and wait for it to be taken; bursts end in a random gap.
  task automatic send_item(input logic [7:0] c, input bit empty, input bit last,
                           input bit given, input logic [1:0] cls);
    in_valid      <= 1'b1;
    in_ua_char    <= c;
    in_no_char    <= empty;
    in_is_last    <= last;
    row_cls_given <= given;
    row_cls       <= cls;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_string(input bit given, input logic [1:0] cls);
    for (int i = 0; i < str_bytes.size(); i++) begin
      send_item(str_bytes[i], str_empty[i], i == str_bytes.size() - 1, given, cls);
    end
    n_strings++;
  endtask

  task automatic push_empty();
    str_bytes = {str_bytes, 8'($urandom_range(0, 255))};
    str_empty = {str_empty, 1'b1};
  endtask

  // Adds a byte, now and then preceded by a byte-less request.
  task automatic add_byte(input logic [7:0] c);
    if ($urandom_range(0, 11) == 0) push_empty();
    str_bytes = {str_bytes, c};
    str_empty = {str_empty, 1'b0};
  endtask

  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
    return c;
  endfunction

  // Mostly filler with embedded markers (some with a letter dropped), some raw noise,
  // a few empty strings.
  task automatic make_random_string();
    int kind;
    int m;
    int drop;
    str_bytes.delete();
    str_empty.delete();
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      repeat ($urandom_range(0, 2)) push_empty();
    end else if (kind < 24) begin
      repeat ($urandom_range(1, 30)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(0, 6)) add_byte(mix_case(8'($urandom_range(32, 126))));
        if ($urandom_range(0, 4) != 0) begin
          m = $urandom_range(0, N_MARK - 1);
          drop = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MARK_LEN[m] - 1) : -1;
          for (int k = MARK_LEN[m] - 1; k >= 0; k--) begin
            if (k != drop) add_byte(mix_case(MARK_TEXT[m][8*k +: 8]));
          end
        end
      end
    end
    if (str_bytes.size() == 0 || $urandom_range(0, 4) == 0) push_empty();
  endtask

  initial begin : main
    int start_items;
    logic [7:0] ch;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Directed strings
    foreach (ua_cases[r]) begin
      str_bytes.delete();
      str_empty.delete();
      for (int i = 0; i < ua_cases[r].text.len(); i++) begin
        if (i == ua_cases[r].gap_at) push_empty();
        ch = ua_cases[r].text[i];
        str_bytes = {str_bytes, ch};
        str_empty = {str_empty, 1'b0};
      end
      if (ua_cases[r].tail_empty) push_empty();
      send_string(ua_cases[r].cls_given, ua_cases[r].cls);
    end

    // Random strings
    start_items = n_items;
    while (n_items - start_items < RAND_ITEMS) begin
      make_random_string();
      send_string(1'b0, uasc_pkg::CLASS_DESKTOP);
    end
    in_valid <= 1'b0;

    while (agent_class_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (agent_class_q.size() != 0) begin
      $display("%0t: %0d classes never arrived", $time, agent_class_q.size());
      err_cnt++;
    end
    $display("%0d strings in %0d requests, %0d classes out (desktop %0d, mobile %0d, bot %0d)",
             n_strings, n_items, n_results, n_class[0], n_class[1], n_class[2]);
    $display("long result hold-off %0s, %0d mismatches", hold_done ? "done" : "skipped",
             err_cnt);
    if (err_cnt == 0) begin
      $display("user_agent_stream_classifier_tb passed");
    end else begin
      $display("user_agent_stream_classifier_tb failed");
    end
    $finish;
  end

endmodule
